>>> hw/rtl/tsq_pkg.sv
// Package for the two-square point finder: item types, constants and state codes.
// Used by every module of the block; it depends on nothing else.
package tsq_pkg;

	localparam int InW            = 48;
	localparam int CoordW         = 24;
	localparam int DW             = 64;
	localparam int PW             = 2 * DW;
	localparam int MaxRes         = 4;
	localparam int ResIdxW        = $clog2(MaxRes);
	localparam int ResCntW        = ResIdxW + 1;
	localparam int ModulusBitsDef = 48;
	localparam int DivCntW        = $clog2(PW) + 1;
	localparam int ShiftCntW      = $clog2(DW) + 1;

	localparam logic [DivCntW-1:0] DivWideBits   = DivCntW'(PW);
	localparam logic [DivCntW-1:0] DivNarrowBits = DivCntW'(DW);

	typedef struct packed {
		logic [InW-1:0]    root;
		logic [InW-1:0]    modulus;
		logic [CoordW-1:0] scale;
	} job_t;

	typedef struct packed {
		logic [CoordW-1:0] point_x;
		logic [CoordW-1:0] point_y;
		logic              point_valid;
		logic              last_point;
	} res_t;

	typedef struct packed {
		logic              valid;
		logic [CoordW-1:0] x;
		logic [CoordW-1:0] y;
	} push_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_SQ, S_DIVP, S_GCD, S_GSHIFT, S_DISPATCH, S_ISQRT,
		S_CFINIT, S_CFDIV, S_CFM1, S_CFM2, S_CFCHK,
		S_F1, S_F2, S_F3, S_F4, S_F5, S_F6,
		S_C1, S_C2, S_C3, S_C4, S_PUSH1, S_PUSH2, S_CNEXT,
		S_FINISH, S_EMIT
	} state_t;

	typedef enum logic [2:0] {
		PH_LOOP, PH_P1A, PH_P1B, PH_P2A, PH_P2B, PH_CFA, PH_CFB
	} phase_t;

	function automatic logic [DW-1:0] mag64(input logic [DW-1:0] x);
		return x[DW-1] ? (~x + DW'(1)) : x;
	endfunction

endpackage

>>> hw/rtl/tsq_mul.sv
// Iterative multiplier: full 128-bit product of two 64-bit operands from four
// 32x32 partial products, one per cycle. Depends on tsq_pkg.
module tsq_mul (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [tsq_pkg::DW-1:0]  a,
	input  logic [tsq_pkg::DW-1:0]  b,
	output logic                    done,
	output logic [tsq_pkg::PW-1:0]  prod
);

	localparam int HW = tsq_pkg::DW / 2;

	logic [tsq_pkg::DW-1:0] a_q, b_q;
	logic [1:0]             ph_q;
	logic                   run_q;
	logic [tsq_pkg::DW-1:0] pp_s1;
	logic [1:0]             ph_s1;
	logic                   pv_s1;
	logic                   done_q;
	logic [tsq_pkg::PW-1:0] acc_q;
	logic [HW-1:0]          opa, opb;
	logic [tsq_pkg::PW-1:0] pp_ext;

	always_comb begin
		opa = ph_q[1] ? a_q[tsq_pkg::DW-1:HW] : a_q[HW-1:0];
		opb = ph_q[0] ? b_q[tsq_pkg::DW-1:HW] : b_q[HW-1:0];
		pp_ext = {{tsq_pkg::DW{1'b0}}, pp_s1};
		case (ph_s1)
			2'd0:    pp_ext = {{tsq_pkg::DW{1'b0}}, pp_s1};
			2'd3:    pp_ext = {pp_s1, {tsq_pkg::DW{1'b0}}};
			default: pp_ext = {{HW{1'b0}}, pp_s1, {HW{1'b0}}};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			ph_q   <= 2'd0;
			pv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= pv_s1 && (ph_s1 == 2'd3);
			pv_s1  <= run_q;
			if (start) begin
				run_q <= 1'b1;
				ph_q  <= 2'd0;
			end else if (run_q) begin
				ph_q <= ph_q + 2'd1;
				if (ph_q == 2'd3) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + pp_ext;
		end
		if (run_q) begin
			pp_s1 <= opa * opb;
			ph_s1 <= ph_q;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

>>> hw/rtl/tsq_div.sv
// Restoring divider, one quotient bit per cycle: 128-bit or 64-bit dividend
// over a 64-bit divisor, 64-bit quotient and remainder. Depends on tsq_pkg.
module tsq_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   wide,
	input  logic [tsq_pkg::PW-1:0] dvd,
	input  logic [tsq_pkg::DW-1:0] dvs,
	output logic                   done,
	output logic [tsq_pkg::DW-1:0] quo,
	output logic [tsq_pkg::DW-1:0] rem
);

	logic [tsq_pkg::PW-1:0]      sh_q;
	logic [tsq_pkg::DW-1:0]      rem_q, quo_q, dvs_q;
	logic [tsq_pkg::DivCntW-1:0] cnt_q;
	logic                        run_q, done_q;
	logic [tsq_pkg::DW:0]        trial;
	logic                        fits;

	always_comb begin
		trial = {rem_q, sh_q[tsq_pkg::PW-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= wide ? tsq_pkg::DivWideBits : tsq_pkg::DivNarrowBits;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tsq_pkg::DivCntW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sh_q  <= wide ? dvd : {dvd[tsq_pkg::DW-1:0], {tsq_pkg::DW{1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
			dvs_q <= dvs;
		end else if (run_q) begin
			sh_q  <= {sh_q[tsq_pkg::PW-2:0], 1'b0};
			quo_q <= {quo_q[tsq_pkg::DW-2:0], fits};
			rem_q <= fits ? (trial[tsq_pkg::DW-1:0] - dvs_q) : trial[tsq_pkg::DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

>>> hw/rtl/tsq_outbuf.sv
// Result buffer: collects up to four points of one input item, then hands them
// out through a registered valid/ready stage. Depends on tsq_pkg.
module tsq_outbuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  tsq_pkg::push_t        push,
	input  logic                  flush,
	output logic                  res_valid,
	input  logic                  res_ready,
	output tsq_pkg::res_t         res_data,
	output logic                  busy
);

	logic [tsq_pkg::CoordW-1:0]  x_q [tsq_pkg::MaxRes];
	logic [tsq_pkg::CoordW-1:0]  y_q [tsq_pkg::MaxRes];
	logic [tsq_pkg::ResCntW-1:0] cnt_q;
	logic [tsq_pkg::ResIdxW-1:0] rd_q;
	logic                        drain_q, valid_q;
	tsq_pkg::res_t               res_q;
	logic                        load, is_last, room, empty;

	always_comb begin
		empty   = cnt_q == '0;
		room    = cnt_q < tsq_pkg::ResCntW'(tsq_pkg::MaxRes);
		load    = drain_q && (!valid_q || res_ready);
		is_last = empty || ({1'b0, rd_q} == (cnt_q - 1'b1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			rd_q    <= '0;
			drain_q <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (clear) begin
				cnt_q <= '0;
			end else if (push.valid && room) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (flush) begin
				drain_q <= 1'b1;
				rd_q    <= '0;
			end else if (load) begin
				if (is_last) begin
					drain_q <= 1'b0;
				end else begin
					rd_q <= rd_q + 1'b1;
				end
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (res_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid && room) begin
			x_q[cnt_q[tsq_pkg::ResIdxW-1:0]] <= push.x;
			y_q[cnt_q[tsq_pkg::ResIdxW-1:0]] <= push.y;
		end
		if (load) begin
			res_q.point_x     <= empty ? '0 : x_q[rd_q];
			res_q.point_y     <= empty ? '0 : y_q[rd_q];
			res_q.point_valid <= !empty;
			res_q.last_point  <= is_last;
		end
	end

	assign res_valid = valid_q;
	assign res_data  = res_q;
	assign busy      = drain_q || valid_q;

endmodule

>>> hw/rtl/two_square_from_root_cfrac_core.sv
// Two-square point finder from a root of -1 and a continued fraction expansion.
// For an in-range item: a wide division for P, a binary gcd of one step per cycle, then
// continued-fraction steps paced by the one-bit-per-cycle divider and the shared multiplier.
// Results leave one per cycle while res_ready is held high; the next item is taken after the
// last result is accepted. Reset clears control state only.
// Depends on tsq_pkg, tsq_mul, tsq_div, tsq_outbuf.
module two_square_from_root_cfrac_core #(
	parameter int MODULUS_BITS = tsq_pkg::ModulusBitsDef
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_ready,
	input  tsq_pkg::job_t job_data,
	output logic          res_valid,
	input  logic          res_ready,
	output tsq_pkg::res_t res_data
);

	localparam int DW = tsq_pkg::DW;
	localparam int PW = tsq_pkg::PW;
	localparam int CW = tsq_pkg::CoordW;
	localparam int IW = tsq_pkg::InW;
	localparam logic [IW-1:0] InMask =
		(MODULUS_BITS >= IW) ? {IW{1'b1}} : ((IW'(1) << MODULUS_BITS) - IW'(1));

	tsq_pkg::state_t state_q, state_d;
	tsq_pkg::phase_t phase_q;
	logic            issued_q;

	logic [IW-1:0]        root_q;
	logic [DW-1:0]        k_q, p_q, lim_q, v_q, f_q, m_q, ga_q, gb_q, bit_q;
	logic [CW-1:0]        e_q, xm_q, ym_q;
	logic signed [DW-1:0] t_q, q_q, u_q, u1_q, u2_q, v1_q, v2_q, a_q, h_q, i_q;
	logic signed [PW-1:0] d_q;
	logic [tsq_pkg::ShiftCntW-1:0] sh_q;
	logic                 pass_q;

	logic          mul_start, mul_done, div_start, div_wide, div_done;
	logic [DW-1:0] mul_a, mul_b, div_dvs, div_quo, div_rem;
	logic [PW-1:0] mul_prod, div_dvd;
	logic          flush, ob_busy;
	tsq_pkg::push_t push;

	logic signed [PW-1:0] hext;
	logic          cond1, cond2, bad_in, lim_out;
	logic [DW-1:0] fsum, a_d, r_d;

	tsq_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	tsq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.wide   (div_wide),
		.dvd    (div_dvd),
		.dvs    (div_dvs),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	tsq_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (job_valid && job_ready),
		.push      (push),
		.flush     (flush),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.busy      (ob_busy)
	);

	always_comb begin
		hext    = {{DW{h_q[DW-1]}}, h_q};
		cond1   = (d_q >= 0) && (d_q <= hext);
		cond2   = (hext <= d_q) && (d_q <= 0);
		bad_in  = (k_q == '0) || ({{(DW-IW){1'b0}}, root_q} >= k_q) || (e_q == '0);
		lim_out = v1_q[DW-1] || (v1_q > lim_q);
		fsum    = f_q + mul_prod[DW-1:0];
		if (u_q[DW-1]) begin
			a_d = (div_rem != '0) ? ~div_quo : (~div_quo + DW'(1));
			r_d = (div_rem != '0) ? (v_q - div_rem) : '0;
		end else begin
			a_d = div_quo;
			r_d = div_rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= tsq_pkg::S_IDLE;
			issued_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_start || div_start) begin
				issued_q <= 1'b1;
			end else if (mul_done || div_done) begin
				issued_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_wide  = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		flush     = 1'b0;
		push      = '0;
		case (state_q)
			tsq_pkg::S_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					state_d = tsq_pkg::S_CHECK;
				end
			end
			tsq_pkg::S_CHECK: begin
				state_d = bad_in ? tsq_pkg::S_FINISH : tsq_pkg::S_SQ;
			end
			tsq_pkg::S_SQ: begin
				mul_a     = tsq_pkg::mag64(t_q);
				mul_b     = tsq_pkg::mag64(t_q);
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = tsq_pkg::S_DIVP;
				end
			end
			tsq_pkg::S_DIVP: begin
				div_wide  = 1'b1;
				div_dvd   = d_q;
				div_dvs   = k_q;
				div_start = !issued_q;
				if (div_done) begin
					state_d = tsq_pkg::S_GCD;
				end
			end
			tsq_pkg::S_GCD: begin
				if (ga_q == '0 || gb_q == '0) begin
					state_d = tsq_pkg::S_GSHIFT;
				end
			end
			tsq_pkg::S_GSHIFT: begin
				if (sh_q == '0) begin
					if (!pass_q) begin
						state_d = tsq_pkg::S_GCD;
					end else if (ga_q == DW'(1)) begin
						state_d = tsq_pkg::S_DISPATCH;
					end else begin
						state_d = tsq_pkg::S_FINISH;
					end
				end
			end
			tsq_pkg::S_DISPATCH: begin
				if (p_q == DW'(1) || p_q == DW'(2)) begin
					state_d = tsq_pkg::S_C1;
				end else begin
					state_d = tsq_pkg::S_ISQRT;
				end
			end
			tsq_pkg::S_ISQRT: begin
				if (bit_q[0]) begin
					state_d = tsq_pkg::S_CFINIT;
				end
			end
			tsq_pkg::S_CFINIT: begin
				state_d = (p_q[DW-2:0] != '0) ? tsq_pkg::S_CFDIV : tsq_pkg::S_FINISH;
			end
			tsq_pkg::S_CFDIV: begin
				div_dvd   = {{DW{1'b0}}, tsq_pkg::mag64(u_q)};
				div_dvs   = v_q;
				div_start = !issued_q;
				if (div_done) begin
					state_d = tsq_pkg::S_CFM1;
				end
			end
			tsq_pkg::S_CFM1, tsq_pkg::S_CFM2: begin
				mul_a     = a_q;
				mul_b     = (state_q == tsq_pkg::S_CFM1) ? u1_q : v1_q;
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = (state_q == tsq_pkg::S_CFM1) ? tsq_pkg::S_CFM2 : tsq_pkg::S_CFCHK;
				end
			end
			tsq_pkg::S_CFCHK: begin
				if (phase_q == tsq_pkg::PH_CFB) begin
					state_d = tsq_pkg::S_C1;
				end else if (lim_out) begin
					state_d = tsq_pkg::S_FINISH;
				end else begin
					state_d = tsq_pkg::S_F1;
				end
			end
			tsq_pkg::S_F1, tsq_pkg::S_F2, tsq_pkg::S_F3, tsq_pkg::S_F4, tsq_pkg::S_F5: begin
				case (state_q)
					tsq_pkg::S_F1: begin mul_a = p_q; mul_b = u1_q; end
					tsq_pkg::S_F2: begin mul_a = m_q; mul_b = u1_q; end
					tsq_pkg::S_F3: begin mul_a = q_q; mul_b = u1_q; end
					tsq_pkg::S_F4: begin mul_a = m_q; mul_b = v1_q; end
					default:       begin mul_a = k_q; mul_b = v1_q; end
				endcase
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = tsq_pkg::state_t'(state_q + 1'b1);
				end
			end
			tsq_pkg::S_F6: begin
				mul_a     = m_q;
				mul_b     = v1_q;
				mul_start = !issued_q;
				if (mul_done) begin
					if (fsum == DW'(1)) begin
						state_d = tsq_pkg::S_C1;
					end else if (v_q != '0) begin
						state_d = tsq_pkg::S_CFDIV;
					end else begin
						state_d = tsq_pkg::S_FINISH;
					end
				end
			end
			tsq_pkg::S_C1, tsq_pkg::S_C2, tsq_pkg::S_C3, tsq_pkg::S_C4: begin
				case (state_q)
					tsq_pkg::S_C1: begin
						mul_a = tsq_pkg::mag64(h_q);
						mul_b = tsq_pkg::mag64(t_q);
					end
					tsq_pkg::S_C2: begin
						mul_a = tsq_pkg::mag64(i_q);
						mul_b = k_q;
					end
					tsq_pkg::S_C3: begin
						mul_a = {{(DW-CW){1'b0}}, d_q[CW-1:0]};
						mul_b = {{(DW-CW){1'b0}}, e_q};
					end
					default: begin
						mul_a = {{(DW-CW){1'b0}}, h_q[CW-1:0]};
						mul_b = {{(DW-CW){1'b0}}, e_q};
					end
				endcase
				mul_start = !issued_q;
				if (mul_done) begin
					state_d = tsq_pkg::state_t'(state_q + 1'b1);
				end
			end
			tsq_pkg::S_PUSH1: begin
				push.valid = cond1;
				push.x     = xm_q;
				push.y     = ym_q;
				state_d    = tsq_pkg::S_PUSH2;
			end
			tsq_pkg::S_PUSH2: begin
				push.valid = cond2;
				push.x     = ~xm_q + CW'(1);
				push.y     = ~ym_q + CW'(1);
				state_d    = tsq_pkg::S_CNEXT;
			end
			tsq_pkg::S_CNEXT: begin
				case (phase_q)
					tsq_pkg::PH_P1A, tsq_pkg::PH_P2A: state_d = tsq_pkg::S_C1;
					tsq_pkg::PH_CFA: begin
						state_d = (v_q != '0) ? tsq_pkg::S_CFDIV : tsq_pkg::S_FINISH;
					end
					default: state_d = tsq_pkg::S_FINISH;
				endcase
			end
			tsq_pkg::S_FINISH: begin
				flush   = 1'b1;
				state_d = tsq_pkg::S_EMIT;
			end
			tsq_pkg::S_EMIT: begin
				if (!ob_busy) begin
					state_d = tsq_pkg::S_IDLE;
				end
			end
			default: state_d = tsq_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tsq_pkg::S_IDLE: begin
				if (job_valid) begin
					root_q <= job_data.root & InMask;
					k_q    <= {{(DW-IW){1'b0}}, job_data.modulus & InMask};
					e_q    <= job_data.scale;
				end
			end
			tsq_pkg::S_CHECK: begin
				if ({root_q, 1'b0} > {1'b0, k_q[IW-1:0]}) begin
					t_q <= {{(DW-IW){1'b0}}, root_q} - k_q;
				end else begin
					t_q <= {{(DW-IW){1'b0}}, root_q};
				end
			end
			tsq_pkg::S_SQ: begin
				if (mul_done) begin
					d_q <= mul_prod + PW'(1);
				end
			end
			tsq_pkg::S_DIVP: begin
				if (div_done) begin
					p_q    <= div_quo;
					q_q    <= ~{t_q[DW-2:0], 1'b0} + DW'(1);
					ga_q   <= div_quo;
					gb_q   <= tsq_pkg::mag64({t_q[DW-2:0], 1'b0});
					sh_q   <= '0;
					pass_q <= 1'b0;
				end
			end
			tsq_pkg::S_GCD: begin
				if (ga_q == '0) begin
					ga_q <= gb_q;
				end else if (gb_q != '0) begin
					if (!ga_q[0] && !gb_q[0]) begin
						ga_q <= ga_q >> 1;
						gb_q <= gb_q >> 1;
						sh_q <= sh_q + 1'b1;
					end else if (!ga_q[0]) begin
						ga_q <= ga_q >> 1;
					end else if (!gb_q[0]) begin
						gb_q <= gb_q >> 1;
					end else if (ga_q >= gb_q) begin
						ga_q <= ga_q - gb_q;
					end else begin
						gb_q <= gb_q - ga_q;
					end
				end
			end
			tsq_pkg::S_GSHIFT: begin
				if (sh_q != '0) begin
					ga_q <= ga_q << 1;
					sh_q <= sh_q - 1'b1;
				end else if (!pass_q) begin
					gb_q   <= k_q;
					pass_q <= 1'b1;
				end
			end
			tsq_pkg::S_DISPATCH: begin
				if (p_q == DW'(1)) begin
					h_q     <= DW'(1);
					i_q     <= '0;
					phase_q <= tsq_pkg::PH_P1A;
				end else if (p_q == DW'(2)) begin
					h_q     <= (-t_q - 64'sd1) >>> 1;
					i_q     <= -64'sd1;
					phase_q <= tsq_pkg::PH_P2A;
				end else begin
					ga_q  <= p_q;
					gb_q  <= '0;
					bit_q <= DW'(1) << (DW - 2);
				end
			end
			tsq_pkg::S_ISQRT: begin
				if (ga_q >= gb_q + bit_q) begin
					ga_q <= ga_q - (gb_q + bit_q);
					gb_q <= (gb_q >> 1) + bit_q;
				end else begin
					gb_q <= gb_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			tsq_pkg::S_CFINIT: begin
				lim_q   <= gb_q;
				u1_q    <= 64'sd1;
				v1_q    <= '0;
				u2_q    <= '0;
				v2_q    <= 64'sd1;
				u_q     <= {t_q[DW-2:0], 1'b0};
				v_q     <= {p_q[DW-2:0], 1'b0};
				phase_q <= tsq_pkg::PH_LOOP;
			end
			tsq_pkg::S_CFDIV: begin
				if (div_done) begin
					a_q <= a_d;
					u_q <= v_q;
					v_q <= r_d;
				end
			end
			tsq_pkg::S_CFM1: begin
				if (mul_done) begin
					u2_q <= u1_q;
					u1_q <= mul_prod[DW-1:0] + u2_q;
				end
			end
			tsq_pkg::S_CFM2: begin
				if (mul_done) begin
					v2_q <= v1_q;
					v1_q <= mul_prod[DW-1:0] + v2_q;
				end
			end
			tsq_pkg::S_CFCHK: begin
				h_q <= u1_q;
				i_q <= v1_q;
			end
			tsq_pkg::S_F1, tsq_pkg::S_F3, tsq_pkg::S_F5: begin
				if (mul_done) begin
					m_q <= mul_prod[DW-1:0];
				end
			end
			tsq_pkg::S_F2: begin
				if (mul_done) begin
					f_q <= mul_prod[DW-1:0];
				end
			end
			tsq_pkg::S_F4: begin
				if (mul_done) begin
					f_q <= fsum;
				end
			end
			tsq_pkg::S_F6: begin
				if (mul_done) begin
					phase_q <= tsq_pkg::PH_CFA;
				end
			end
			tsq_pkg::S_C1: begin
				if (mul_done) begin
					d_q <= (h_q[DW-1] ^ t_q[DW-1]) ? (~mul_prod + PW'(1)) : mul_prod;
				end
			end
			tsq_pkg::S_C2: begin
				if (mul_done) begin
					d_q <= i_q[DW-1] ? (d_q + mul_prod) : (d_q - mul_prod);
				end
			end
			tsq_pkg::S_C3: begin
				if (mul_done) begin
					xm_q <= mul_prod[CW-1:0];
				end
			end
			tsq_pkg::S_C4: begin
				if (mul_done) begin
					ym_q <= mul_prod[CW-1:0];
				end
			end
			tsq_pkg::S_CNEXT: begin
				case (phase_q)
					tsq_pkg::PH_P1A: begin
						h_q     <= -t_q;
						i_q     <= -64'sd1;
						phase_q <= tsq_pkg::PH_P1B;
					end
					tsq_pkg::PH_P2A: begin
						h_q     <= (-t_q + 64'sd1) >>> 1;
						i_q     <= -64'sd1;
						phase_q <= tsq_pkg::PH_P2B;
					end
					tsq_pkg::PH_CFA: begin
						phase_q <= tsq_pkg::PH_CFB;
					end
					default: phase_q <= phase_q;
				endcase
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_ready_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		job_ready |-> !res_valid)
		else $error("input taken while a result is still pending");

	a_invalid_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_data.point_valid) |->
			(res_data.last_point && res_data.point_x == '0 && res_data.point_y == '0))
		else $error("item without a point is not a clean final item");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(job_valid && job_ready) |=> !job_ready)
		else $error("ready stayed high after an item was accepted");
`endif

endmodule

>>> tb/tsq_point_checker.sv
// Checker for the two-square point finder: watches both channels, works out the points
// each accepted item must yield and compares every result item against them.
// Depends on tsq_pkg for the item types.
`timescale 1ns / 100ps
module tsq_point_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  logic          job_ready,
	input  tsq_pkg::job_t job_data,
	input  logic          res_valid,
	input  logic          res_ready,
	input  tsq_pkg::res_t res_data,
	output int            errors,
	output int            pending,
	output int            points_seen
);

	tsq_pkg::res_t points_due[$];
	tsq_pkg::res_t found[$];
	longint cur_t;
	longint cur_k;
	logic [63:0] cur_e;

	initial begin
		errors = 0;
		pending = 0;
		points_seen = 0;
	end

	task automatic report(input string what, input tsq_pkg::res_t got,
			input tsq_pkg::res_t want);
		errors++;
		$display("%0t mismatch (%s): got x=%0d y=%0d v=%0b l=%0b, want x=%0d y=%0d v=%0b l=%0b",
			$realtime, what, got.point_x, got.point_y, got.point_valid, got.last_point,
			want.point_x, want.point_y, want.point_valid, want.last_point);
	endtask

	function automatic logic [63:0] absval(input longint a);
		return a < 0 ? 64'(-a) : 64'(a);
	endfunction

	function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint half_down(input longint x);
		return x >= 0 ? x / 2 : -((-x + 1) / 2);
	endfunction

	task automatic add_point(input logic [63:0] x, input logic [63:0] y);
		tsq_pkg::res_t r;
		if (found.size() < tsq_pkg::MaxRes) begin
			r.point_x = x[tsq_pkg::CoordW-1:0];
			r.point_y = y[tsq_pkg::CoordW-1:0];
			r.point_valid = 1'b1;
			r.last_point = 1'b0;
			found = {found, r};
		end
	endtask

	task automatic try_pair(input longint h, input longint i);
		logic signed [127:0] hs, ts, is, ks, d;
		logic [63:0] hu;
		hs = h;
		ts = cur_t;
		is = i;
		ks = cur_k;
		hu = h;
		d = hs * ts - is * ks;
		if (d >= 0 && d <= hs) add_point(d[63:0] * cur_e, hu * cur_e);
		if (hs <= d && d <= 0) add_point((-d[63:0]) * cur_e, (-hu) * cur_e);
	endtask

	task automatic cf_advance(inout longint u, inout longint v, inout longint u1,
			inout longint u2, inout longint v1, inout longint v2);
		longint a, r, n1;
		a = u / v;
		if (u % v != 0 && u < 0) a -= 1;
		r = u - a * v;
		u = v;
		v = r;
		n1 = a * u1 + u2;
		u2 = u1;
		u1 = n1;
		n1 = a * v1 + v2;
		v2 = v1;
		v1 = n1;
	endtask

	task automatic find_points(input logic [63:0] root, input logic [63:0] k);
		longint t, q, g, u, v, u1, u2, v1, v2;
		logic [127:0] sq;
		logic [63:0] p, lim, f;
		t = root;
		if (2 * root > k) t -= longint'(k);
		cur_t = t;
		cur_k = k;
		sq = absval(t);
		sq = sq * sq + 128'd1;
		p = 64'(sq / {64'd0, k});
		q = -2 * t;
		if (gcd64(gcd64(p, absval(q)), k) != 1) return;
		g = -t;
		if (p == 1) begin
			try_pair(1, 0);
			try_pair(g, -1);
			return;
		end
		if (p == 2) begin
			try_pair(half_down(g - 1), -1);
			try_pair(half_down(g + 1), -1);
			return;
		end
		lim = root_floor(p);
		u1 = 1;
		v1 = 0;
		u2 = 0;
		v2 = 1;
		u = -q;
		v = p << 1;
		while (v != 0) begin
			cf_advance(u, v, u1, u2, v1, v2);
			if (v1 < 0 || 64'(v1) > lim) break;
			f = p * 64'(u1) * 64'(u1) + 64'(q) * 64'(u1) * 64'(v1) + k * 64'(v1) * 64'(v1);
			if (f == 1) begin
				try_pair(u1, v1);
				if (v != 0) begin
					cf_advance(u, v, u1, u2, v1, v2);
					try_pair(u1, v1);
				end
				break;
			end
		end
	endtask

	task automatic predict_points(input tsq_pkg::job_t j);
		tsq_pkg::res_t none;
		found.delete();
		cur_e = j.scale;
		if (j.modulus != 0 && j.root < j.modulus && j.scale != 0)
			find_points(j.root, j.modulus);
		if (found.size() == 0) begin
			none = '0;
			none.last_point = 1'b1;
			found = {found, none};
		end else begin
			found[found.size() - 1].last_point = 1'b1;
		end
		foreach (found[n]) points_due = {points_due, found[n]};
	endtask

	always @(posedge clk) begin
		tsq_pkg::res_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (res_data.point_valid) points_seen++;
				if (points_due.size() == 0) begin
					report("unexpected item", res_data, '0);
				end else begin
					want = points_due.pop_front();
					if (res_data.point_x != want.point_x) report("point_x", res_data, want);
					if (res_data.point_y != want.point_y) report("point_y", res_data, want);
					if (res_data.point_valid != want.point_valid)
						report("point_valid", res_data, want);
					if (res_data.last_point != want.last_point)
						report("last_point", res_data, want);
				end
			end
			if (job_valid && job_ready) predict_points(job_data);
			pending = points_due.size();
		end
	end

endmodule

>>> tb/two_square_from_root_cfrac_core_test.sv
// Testbench top for the two-square point finder: clock, reset, stimulus and verdict.
// Depends on tsq_pkg, the block and tsq_point_checker.
`timescale 1ns / 100ps
module two_square_from_root_cfrac_core_test;

	logic          clk;
	logic          arst_n;
	logic          job_valid;
	logic          job_ready;
	tsq_pkg::job_t job_data;
	logic          res_valid;
	logic          res_ready;
	tsq_pkg::res_t res_data;
	int   errors;
	int   pending;
	int   points_seen;
	int   jobs_sent;
	int   stall_left;
	bit   quiet;

	two_square_from_root_cfrac_core uut (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_ready(job_ready), .job_data(job_data),
		.res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
	);

	tsq_point_checker chk (
		.clk(clk), .arst_n(arst_n),
		.job_valid(job_valid), .job_ready(job_ready), .job_data(job_data),
		.res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
		.errors(errors), .pending(pending), .points_seen(points_seen)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	initial begin
		stall_left = 0;
		res_ready = 1'b0;
	end

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 2);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	task automatic send_job(input logic [47:0] root, input logic [47:0] modulus,
			input logic [23:0] scale);
		int gap;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 3);
			job_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		job_valid <= 1'b1;
		job_data <= '{root: root, modulus: modulus, scale: scale};
		do @(posedge clk); while (!job_ready);
		jobs_sent++;
	endtask

	// The sender goes idle and waits until every expected result has come.
	task automatic wait_drained();
		@(negedge clk);
		job_valid <= 1'b0;
		wait (pending == 0);
	endtask

	function automatic logic [63:0] gcd_u(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		while (b != 0) begin
			r = a % b;
			a = b;
			b = r;
		end
		return a;
	endfunction

	function automatic longint inverse_mod(input longint a, input longint m);
		longint t0, t1, r0, r1, qq, tmp;
		t0 = 0;
		t1 = 1;
		r0 = m;
		r1 = a % m;
		while (r1 != 0) begin
			qq = r0 / r1;
			tmp = r0 - qq * r1;
			r0 = r1;
			r1 = tmp;
			tmp = t0 - qq * t1;
			t0 = t1;
			t1 = tmp;
		end
		return t0 < 0 ? t0 + m : t0;
	endfunction

	// Coprime x < y give K = x*x + y*y and root t = x / y mod K, or K - t if other_root.
	task automatic send_pair(input longint x, input longint y, input logic [23:0] scale,
			input bit other_root);
		longint k, t;
		logic [127:0] prod;
		k = x * x + y * y;
		prod = 128'(x) * 128'(inverse_mod(y, k));
		t = longint'(prod % 128'(k));
		if (other_root && t != 0) t = k - t;
		send_job(48'(t), 48'(k), scale);
	endtask

	task automatic send_random_pair();
		longint x, y;
		logic [23:0] scale;
		do begin
			case ($urandom_range(0, 3))
				0: y = $urandom_range(1, 30);
				1: y = $urandom_range(1, 3000);
				2: y = $urandom_range(1, 200000);
				default: y = $urandom_range(1, 24'hFF_FFFF >> 1);
			endcase
			x = $urandom_range(0, int'(y));
		end while (gcd_u(x, y) != 1);
		scale = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'($urandom_range(1, 255));
		if (scale == 0) scale = 1;
		send_pair(x, y, scale, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		logic [47:0] r48, m48;
		quiet = 1'b0;
		jobs_sent = 0;
		arst_n = 1'b0;
		job_valid = 1'b0;
		job_data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_job(48'd0, 48'd1, 24'd1);
		send_job(48'd1, 48'd2, 24'd3);
		send_job(48'd2, 48'd5, 24'd1);
		send_job(48'd3, 48'd5, 24'd7);
		send_job(48'd7, 48'd25, 24'd1);
		send_job(48'd3, 48'd10, 24'd2);
		send_job(48'd5, 48'd13, 24'hFF_FFFF);
		send_job(48'd5, 48'd5, 24'd1);
		send_job(48'd9, 48'd5, 24'd1);
		send_job(48'd2, 48'd0, 24'd1);
		send_job(48'd2, 48'd5, 24'd0);
		send_job(48'hFFFF_FFFF_FFFE, 48'hFFFF_FFFF_FFFF, 24'hFF_FFFF);
		send_job(48'h0, 48'hFFFF_FFFF_FFFF, 24'd1);
		send_job(48'd4, 48'd9, 24'd1);
		send_pair(1, 2, 24'd1, 0);
		send_pair(3, 8, 24'd1, 1);
		send_pair(24'h7F_FFFE, 24'h7F_FFFF, 24'hFF_FFFF, 0);
		send_pair(24'h40_0001, 24'h7F_FFFF, 24'd1, 1);
		send_pair(12345, 67891, 24'd100, 0);

		wait_drained();

		for (int n = 0; n < 300; n++) begin
			if (n == 260) quiet = 1'b1;
			if (n == 120) wait_drained();
			if ($urandom_range(0, 4) != 0) begin
				send_random_pair();
			end else begin
				r48 = 48'({$urandom, $urandom});
				m48 = 48'({$urandom, $urandom});
				if ($urandom_range(0, 1)) m48 = m48 >> $urandom_range(0, 40);
				if ($urandom_range(0, 1) && m48 != 0) r48 = r48 % m48;
				send_job(r48, m48, 24'($urandom));
			end
		end
		wait_drained();
		repeat (100) @(posedge clk);
		$display("Sent %0d items (well-formed roots, edge cases and noise); %0d points seen.",
			jobs_sent, points_seen);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("Timeout with %0d result items outstanding.", pending);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/tsq_pkg.sv
hw/rtl/tsq_mul.sv
hw/rtl/tsq_div.sv
hw/rtl/tsq_outbuf.sv
hw/rtl/two_square_from_root_cfrac_core.sv
tb/tsq_point_checker.sv
tb/two_square_from_root_cfrac_core_test.sv
